// File: design/pal_pkg.sv
package pal_pkg;

	// Operation codes carried in the kind field of a command.
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	// Status codes reported with every result.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// Fixed widths of the port fields.
	localparam int POS_W   = 7;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 8;

	// One command transfer.
	typedef struct packed {
		logic [1:0]                kind;
		logic [POS_W-1:0]          position;
		logic signed [VALUE_W-1:0] value_in;
	} cmd_t;

	// One result transfer.
	typedef struct packed {
		logic [1:0]                status;
		logic signed [VALUE_W-1:0] value_out;
		logic [COUNT_W-1:0]        count;
	} rsp_t;

	// Per-cell update control for the shifting row.
	typedef struct packed {
		logic load;
		logic up;
		logic down;
	} cell_ctl_t;

endpackage

// File: design/pal_cell.sv
module pal_cell #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  pal_pkg::cell_ctl_t    ctl,
	input  logic [DATA_WIDTH-1:0] up_data,
	input  logic [DATA_WIDTH-1:0] down_data,
	input  logic [DATA_WIDTH-1:0] load_data,
	output logic [DATA_WIDTH-1:0] entry
);
	import pal_pkg::*;

	logic [DATA_WIDTH-1:0] entry_q;

	// A load takes the new value; otherwise the cell takes the entry of the
	// lower neighbor on an insert or of the upper neighbor on a remove.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= load_data;
		end else if (ctl.up) begin
			entry_q <= up_data;
		end else if (ctl.down) begin
			entry_q <= down_data;
		end
	end

	assign entry = entry_q;

endmodule

// File: design/positional_array_list_core.sv
// Positional array list: a bounded ordered list of words held in a row of
// DEPTH register cells together with a count of the entries held.
//
// Command channel: cmd carries kind, position and value_in. A command
// transfer happens at a rising edge where start is high and busy is low.
// busy stays low, so a command may be issued in every cycle.
// Result channel: done is high for exactly one cycle, the cycle after the
// command transfer, and rsp then holds status, value_out and count. The
// receiver cannot stall; a result not taken in its cycle is gone.
//
// Throughput is one command per cycle. Every cell takes its neighbor's
// entry at the same edge, so an insert or remove moves all later entries
// together; the read path is a one-hot select over the row into the
// result register.
//
// Reset clears the count and the result strobe. The cell contents are not
// reset: only cells below the count are ever read, and each was written.
module positional_array_list_core #(
	parameter int DEPTH      = 128,
	parameter int DATA_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pal_pkg::cmd_t  cmd,
	output logic           done,
	output pal_pkg::rsp_t  rsp
);
	import pal_pkg::*;

	localparam int HELD_W = $clog2(DEPTH + 1);
	localparam int CMP_W  = (HELD_W > POS_W) ? HELD_W : POS_W;

	logic [HELD_W-1:0]     held_q;
	logic                  done_q;
	rsp_t                  rsp_q;
	logic                  accept;
	logic [CMP_W-1:0]      pos_x;
	logic [CMP_W-1:0]      held_x;
	logic                  is_full;
	logic                  is_empty;
	logic                  ins_ok;
	logic                  rm_ok;
	logic                  rd_ok;
	logic [1:0]            status_d;
	logic [DATA_WIDTH-1:0] store_val;
	logic [DATA_WIDTH-1:0] sel_val;
	logic [VALUE_W-1:0]    sel_wide;
	logic [DATA_WIDTH-1:0] entry [DEPTH];
	logic                  eq    [DEPTH];
	logic                  gt    [DEPTH];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign pos_x  = CMP_W'(cmd.position);
	assign held_x = CMP_W'(held_q);

	assign is_full  = (held_q == HELD_W'(DEPTH));
	assign is_empty = (held_q == '0);

	// Command decode and status.
	always_comb begin
		ins_ok   = 1'b0;
		rm_ok    = 1'b0;
		rd_ok    = 1'b0;
		status_d = ST_RANGE;
		unique case (cmd.kind) inside
			KIND_INSERT: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else if (pos_x > held_x) begin
					status_d = ST_RANGE;
				end else begin
					status_d = ST_OK;
					ins_ok   = accept;
				end
			end
			KIND_REMOVE, KIND_READ: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else if (pos_x >= held_x) begin
					status_d = ST_RANGE;
				end else begin
					status_d = ST_OK;
					rm_ok    = accept && (cmd.kind == KIND_REMOVE);
					rd_ok    = accept && (cmd.kind == KIND_READ);
				end
			end
			default: begin
				status_d = ST_RANGE;
			end
		endcase
	end

	// Stored form of the insert value: its low DATA_WIDTH bits, or zero-extended when DATA_WIDTH exceeds VALUE_W.
	generate
		if (DATA_WIDTH <= VALUE_W) begin : g_store_narrow
			assign store_val = cmd.value_in[DATA_WIDTH-1:0];
		end else begin : g_store_wide
			assign store_val = {{(DATA_WIDTH-VALUE_W){1'b0}}, cmd.value_in};
		end
	endgenerate

	// The row of cells; each compares its own index with the position.
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			cell_ctl_t             ctl;
			logic [DATA_WIDTH-1:0] up_d;
			logic [DATA_WIDTH-1:0] down_d;

			assign eq[gi]   = (pos_x == CMP_W'(gi));
			assign gt[gi]   = (CMP_W'(gi) > pos_x);
			assign ctl.load = ins_ok && eq[gi];
			assign ctl.up   = ins_ok && gt[gi];
			assign ctl.down = rm_ok && (gt[gi] || eq[gi]);

			if (gi == 0) begin : g_first
				assign up_d = store_val;
			end else begin : g_mid
				assign up_d = entry[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign down_d = entry[gi];
			end else begin : g_inner
				assign down_d = entry[gi+1];
			end

			pal_cell #(
				.DATA_WIDTH(DATA_WIDTH)
			) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.up_data   (up_d),
				.down_data (down_d),
				.load_data (store_val),
				.entry     (entry[gi])
			);
		end
	endgenerate

	// One-hot select of the addressed entry.
	always_comb begin
		sel_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_val = sel_val | (eq[i] ? entry[i] : '0);
		end
	end

	// Sign-extend the selected entry to the port width, or keep its low VALUE_W bits when it is wider.
	generate
		if (DATA_WIDTH >= VALUE_W) begin : g_out_wide
			assign sel_wide = sel_val[VALUE_W-1:0];
		end else begin : g_out_narrow
			assign sel_wide = {{(VALUE_W-DATA_WIDTH){sel_val[DATA_WIDTH-1]}}, sel_val};
		end
	endgenerate

	// Count update and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (ins_ok) begin
				held_q <= held_q + HELD_W'(1);
			end else if (rm_ok) begin
				held_q <= held_q - HELD_W'(1);
			end
		end
	end

	// Result register; the count reflects the state after this command.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status    <= status_d;
			rsp_q.value_out <= (rm_ok || rd_ok) ? sel_wide : '0;
			if (ins_ok) begin
				rsp_q.count <= COUNT_W'(held_q + HELD_W'(1));
			end else if (rm_ok) begin
				rsp_q.count <= COUNT_W'(held_q - HELD_W'(1));
			end else begin
				rsp_q.count <= COUNT_W'(held_q);
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// A result appears only in the cycle after a command transfer.
	a_done_follows_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result strobe without a preceding command transfer");

	// The count never exceeds the number of cells.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(DEPTH))
		else $error("entry count beyond list depth");

	// A failed operation returns a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp_q.status != ST_OK) |-> (rsp_q.value_out == '0))
		else $error("nonzero value with an error status");

	// A read never changes the count.
	a_read_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.kind == KIND_READ) |=> $stable(held_q))
		else $error("count changed by a read");

	// Insert and remove are never granted together.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ins_ok && rm_ok))
		else $error("insert and remove granted in one cycle");

endmodule
